### sv/eihc_pkg.sv
// Shared types and constants for the Ethernet/IPv4 header classifier.
// No dependencies; every other file of the block imports this package.
package eihc_pkg;

    // Frame byte counter width; the counter saturates at all ones.
    localparam int LENGTH_BITS = 16;
    localparam int CAP_BITS    = LENGTH_BITS + 1;

    // Frame record queue between parser and classifier.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [7:0]  ETH_HDR_BYTES = 8'd14;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [15:0] TYPE_ARP      = 16'h0806;
    localparam logic [15:0] TYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] SECURE_PORT_RESET = 16'd443;
    localparam logic [7:0]  ASCII_H       = 8'h48;
    localparam logic [7:0]  ASCII_G       = 8'h47;
    localparam logic [31:0] WORD_HTTP     = 32'h48545450;
    localparam logic [31:0] WORD_GET      = 32'h47455420;

    typedef enum logic [2:0] {
        CLASS_UNKNOWN = 3'd0,
        CLASS_TCP     = 3'd1,
        CLASS_UDP     = 3'd2,
        CLASS_HTTP    = 3'd3,
        CLASS_HTTPS   = 3'd4,
        CLASS_ARP     = 3'd5
    } t_frame_class;

    typedef enum logic [1:0] {
        LINK_OTHER = 2'd0,
        LINK_ARP   = 2'd1,
        LINK_IPV4  = 2'd2
    } t_link_kind;

    // Everything the parser captured for one frame, including its last byte.
    typedef struct packed {
        logic [47:0]         mac_src;
        logic [47:0]         mac_dst;
        logic [15:0]         ethertype;
        logic [5:0]          ip_hdr_bytes;
        logic [7:0]          ip_proto;
        logic [63:0]         ip_addrs;     // source high, destination low
        logic [63:0]         transport;    // sport 63:48, dport 47:32, seq 31:0
        logic [5:0]          tcp_hdr_bytes;
        logic [7:0]          tcp_flags;
        logic [31:0]         payload_head;
        logic [2:0]          head_count;
        logic [CAP_BITS-1:0] cap_len;
    } t_frame_rec;

endpackage

### sv/eihc_ifs.sv
// Handshake channels of the header classifier: frame bytes in, results out.
// Depends on eihc_pkg for the result field types.
interface eihc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eihc_result_if;
    import eihc_pkg::*;

    logic         valid;
    logic         ready;
    t_frame_class frame_class;
    t_link_kind   link_kind;
    logic [47:0]  src_mac;
    logic [47:0]  dst_mac;
    logic [31:0]  src_ip;
    logic [31:0]  dst_ip;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [7:0]   tcp_flag_bits;
    logic [31:0]  seq_num;
    logic [15:0]  pay_len;
    logic         header_error;

    modport source (
        output valid, output frame_class, output link_kind, output src_mac,
        output dst_mac, output src_ip, output dst_ip,
        output src_port, output dst_port, output tcp_flag_bits,
        output seq_num, output pay_len, output header_error,
        input ready
    );
    modport sink (
        input valid, input frame_class, input link_kind, input src_mac,
        input dst_mac, input src_ip, input dst_ip,
        input src_port, input dst_port, input tcp_flag_bits,
        input seq_num, input pay_len, input header_error,
        output ready
    );
endinterface

### sv/eihc_parser.sv
// Front end: takes one frame byte per beat and captures header fields by offset.
// Depends on eihc_pkg and eihc_byte_if; hands a frame record to the queue.
module eihc_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    eihc_byte_if.sink            i_byte,
    input  logic                 i_full,
    output logic                 o_push,
    output eihc_pkg::t_frame_rec o_rec
);
    import eihc_pkg::*;

    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [47:0] r_mac_src, n_mac_src;
    logic [47:0] r_mac_dst, n_mac_dst;
    logic [15:0] r_ethertype, n_ethertype;
    logic [5:0]  r_ihb, n_ihb;
    logic [7:0]  r_proto, n_proto;
    logic [63:0] r_ip, n_ip;
    logic [63:0] r_tp, n_tp;
    logic [5:0]  r_thb, n_thb;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_head, n_head;
    logic [2:0]  r_cnt, n_cnt;

    logic                   accept;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] ip_end;
    logic [LENGTH_BITS-1:0] tp_off;
    logic                   in_transport;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;
    assign b            = i_byte.data_byte;

    assign ip_end       = LENGTH_BITS'(ETH_HDR_BYTES) + LENGTH_BITS'(r_ihb);
    assign tp_off       = r_pos - ip_end;
    assign in_transport = (r_ihb >= MIN_HDR_BYTES) && (r_pos >= ip_end);

    always_comb begin
        n_pos       = (r_pos == '1) ? r_pos : r_pos + 1'b1;
        n_mac_src   = r_mac_src;
        n_mac_dst   = r_mac_dst;
        n_ethertype = r_ethertype;
        n_ihb       = r_ihb;
        n_proto     = r_proto;
        n_ip        = r_ip;
        n_tp        = r_tp;
        n_thb       = r_thb;
        n_flags     = r_flags;
        n_head      = r_head;
        n_cnt       = r_cnt;

        for (int k = 0; k < 6; k++) begin
            if (r_pos == LENGTH_BITS'(k)) n_mac_dst[8*(5-k) +: 8] = b;
            if (r_pos == LENGTH_BITS'(6 + k)) n_mac_src[8*(5-k) +: 8] = b;
        end
        for (int k = 0; k < 2; k++) begin
            if (r_pos == LENGTH_BITS'(12 + k)) n_ethertype[8*(1-k) +: 8] = b;
        end

        if (r_ethertype == TYPE_IPV4) begin
            if (r_pos == LENGTH_BITS'(ETH_HDR_BYTES)) n_ihb = {b[3:0], 2'b00};
            if (r_pos == LENGTH_BITS'(ETH_HDR_BYTES) + LENGTH_BITS'(9)) n_proto = b;
            for (int k = 0; k < 8; k++) begin
                if (r_pos == LENGTH_BITS'(ETH_HDR_BYTES) + LENGTH_BITS'(12 + k))
                    n_ip[8*(7-k) +: 8] = b;
            end

            if (in_transport) begin
                if (r_proto == PROTO_TCP) begin
                    for (int k = 0; k < 8; k++) begin
                        if (tp_off == LENGTH_BITS'(k)) n_tp[8*(7-k) +: 8] = b;
                    end
                    if (tp_off == LENGTH_BITS'(12)) n_thb = {b[7:4], 2'b00};
                    if (tp_off == LENGTH_BITS'(13)) n_flags = b;
                    // Keep the first four payload bytes for the HTTP match.
                    if (r_thb >= MIN_HDR_BYTES && tp_off >= LENGTH_BITS'(r_thb)
                        && r_cnt < 3'd4) begin
                        case (r_cnt[1:0])
                            2'd0:    n_head[31:24] = b;
                            2'd1:    n_head[23:16] = b;
                            2'd2:    n_head[15:8]  = b;
                            default: n_head[7:0]   = b;
                        endcase
                        n_cnt = r_cnt + 3'd1;
                    end
                end else if (r_proto == PROTO_UDP) begin
                    for (int k = 0; k < 4; k++) begin
                        if (tp_off == LENGTH_BITS'(k)) n_tp[8*(7-k) +: 8] = b;
                    end
                end
            end
        end
    end

    always_comb begin
        o_push              = accept && i_byte.last_byte;
        o_rec.mac_src       = n_mac_src;
        o_rec.mac_dst       = n_mac_dst;
        o_rec.ethertype     = n_ethertype;
        o_rec.ip_hdr_bytes  = n_ihb;
        o_rec.ip_proto      = n_proto;
        o_rec.ip_addrs      = n_ip;
        o_rec.transport     = n_tp;
        o_rec.tcp_hdr_bytes = n_thb;
        o_rec.tcp_flags     = n_flags;
        o_rec.payload_head  = n_head;
        o_rec.head_count    = n_cnt;
        o_rec.cap_len       = CAP_BITS'(r_pos) + CAP_BITS'(1);
    end

    // Clear all per-frame state on reset and after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_byte.last_byte)) begin
            r_pos       <= '0;
            r_mac_src   <= '0;
            r_mac_dst   <= '0;
            r_ethertype <= '0;
            r_ihb       <= '0;
            r_proto     <= '0;
            r_ip        <= '0;
            r_tp        <= '0;
            r_thb       <= '0;
            r_flags     <= '0;
            r_head      <= '0;
            r_cnt       <= '0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_mac_src   <= n_mac_src;
            r_mac_dst   <= n_mac_dst;
            r_ethertype <= n_ethertype;
            r_ihb       <= n_ihb;
            r_proto     <= n_proto;
            r_ip        <= n_ip;
            r_tp        <= n_tp;
            r_thb       <= n_thb;
            r_flags     <= n_flags;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
        end
    end

endmodule

### sv/eihc_queue.sv
// Short queue of captured frame records between parser and classifier.
// Depends on eihc_pkg for the record type and the depth.
module eihc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  eihc_pkg::t_frame_rec i_wr_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output eihc_pkg::t_frame_rec o_rd_data
);
    import eihc_pkg::*;

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full    = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_next(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

### sv/eihc_classify.sv
// Back end: turns a captured frame record into one classification result.
// Depends on eihc_pkg and eihc_result_if; holds the HTTPS port register.
module eihc_classify (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_rec_valid,
    input  eihc_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    eihc_result_if.source        o_result
);
    import eihc_pkg::*;

    logic [15:0]  r_secure_port;
    logic         r_valid;

    t_frame_class r_class, n_class;
    t_link_kind   r_link, n_link;
    logic [47:0]  r_mac_src, r_mac_dst;
    logic [63:0]  r_ips, n_ips;
    logic [15:0]  r_sport, n_sport;
    logic [15:0]  r_dport, n_dport;
    logic [7:0]   r_flags, n_flags;
    logic [31:0]  r_seq, n_seq;
    logic [15:0]  r_plen, n_plen;
    logic         r_err, n_err;

    logic [7:0]          hdrs;
    logic [CAP_BITS-1:0] plen_wide;
    logic [7:0]          first_byte;
    logic                is_http;

    // Advance whenever the output register is free or being drained.
    assign o_pop = i_rec_valid && (!r_valid || o_result.ready);

    assign hdrs       = ETH_HDR_BYTES + 8'(i_rec.ip_hdr_bytes) + 8'(i_rec.tcp_hdr_bytes);
    assign plen_wide  = (i_rec.cap_len > CAP_BITS'(hdrs)) ?
                        i_rec.cap_len - CAP_BITS'(hdrs) : '0;
    assign first_byte = (i_rec.head_count != 3'd0) ? i_rec.payload_head[31:24] : 8'd0;
    assign is_http    = (i_rec.head_count >= 3'd4) &&
                        (i_rec.payload_head == WORD_HTTP || i_rec.payload_head == WORD_GET);

    always_comb begin
        n_class = CLASS_UNKNOWN;
        n_link  = LINK_OTHER;
        n_ips   = '0;
        n_sport = '0;
        n_dport = '0;
        n_flags = '0;
        n_seq   = '0;
        n_plen  = '0;
        n_err   = 1'b0;

        if (i_rec.ethertype == TYPE_ARP) begin
            n_link  = LINK_ARP;
            n_class = CLASS_ARP;
        end else if (i_rec.ethertype == TYPE_IPV4) begin
            n_link = LINK_IPV4;
            n_ips  = i_rec.ip_addrs;
            if (i_rec.ip_hdr_bytes < MIN_HDR_BYTES) begin
                n_err = 1'b1;
            end else if (i_rec.ip_proto == PROTO_UDP) begin
                n_class = CLASS_UDP;
                n_sport = i_rec.transport[63:48];
                n_dport = i_rec.transport[47:32];
            end else if (i_rec.ip_proto == PROTO_TCP) begin
                n_sport = i_rec.transport[63:48];
                n_dport = i_rec.transport[47:32];
                n_seq   = i_rec.transport[31:0];
                n_flags = i_rec.tcp_flags;
                if (i_rec.tcp_hdr_bytes < MIN_HDR_BYTES) begin
                    n_err = 1'b1;
                end else begin
                    n_plen  = 16'(plen_wide);
                    n_class = CLASS_TCP;
                    if (is_http) begin
                        n_class = CLASS_HTTP;
                    end else if (first_byte != ASCII_H && first_byte != ASCII_G &&
                                 (n_sport == r_secure_port || n_dport == r_secure_port)) begin
                        n_class = CLASS_HTTPS;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secure_port <= SECURE_PORT_RESET;
        end else if (i_cfg_we) begin
            r_secure_port <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_class   <= n_class;
            r_link    <= n_link;
            r_mac_src <= i_rec.mac_src;
            r_mac_dst <= i_rec.mac_dst;
            r_ips     <= n_ips;
            r_sport   <= n_sport;
            r_dport   <= n_dport;
            r_flags   <= n_flags;
            r_seq     <= n_seq;
            r_plen    <= n_plen;
            r_err     <= n_err;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.frame_class   = r_class;
    assign o_result.link_kind     = r_link;
    assign o_result.src_mac       = r_mac_src;
    assign o_result.dst_mac       = r_mac_dst;
    assign o_result.src_ip        = r_ips[63:32];
    assign o_result.dst_ip        = r_ips[31:0];
    assign o_result.src_port      = r_sport;
    assign o_result.dst_port      = r_dport;
    assign o_result.tcp_flag_bits = r_flags;
    assign o_result.seq_num       = r_seq;
    assign o_result.pay_len       = r_plen;
    assign o_result.header_error  = r_err;

endmodule

### sv/ethernet_ipv4_header_classifier.sv
// Top level of the Ethernet/IPv4 header classifier: parser, queue, classifier.
// Depends on eihc_pkg, eihc_ifs, eihc_parser, eihc_queue and eihc_classify.
//
//   channel    dir   handshake          carries
//   i_byte     in    valid/ready        data_byte, last_byte
//   o_result   out   valid/ready        one classification per frame
//   i_cfg_*    in    write enable only  secure_web_port (16 bits)
//
// One frame byte is taken every cycle unless the record queue is full; each
// byte only updates the capture registers at its offset. A last byte writes
// the record into the queue; the classifier's output register then drives o_result.
// Reset clears all frame state, empties the queue and sets the HTTPS port to 443.
// i_byte.ready drops only while the two-entry record queue is full.
module ethernet_ipv4_header_classifier (
    input  logic          i_clk,
    input  logic          i_rst_n,
    eihc_byte_if.sink     i_byte,
    eihc_result_if.source o_result,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);
    import eihc_pkg::*;

    t_frame_rec push_rec, pop_rec;
    logic       push, full, pop, rec_valid;

    eihc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    eihc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_rec),
        .o_full    (full),
        .i_pop     (pop),
        .o_valid   (rec_valid),
        .o_rd_data (pop_rec)
    );

    eihc_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rec_valid (rec_valid),
        .i_rec       (pop_rec),
        .o_pop       (pop),
        .o_result    (o_result)
    );

endmodule
